// ===== rtl/core/pdc_pkg.sv =====
// pdc_pkg: shared types, field widths and register indexes of the pid core
// used by every module under rtl/core; depends on nothing
package pdc_pkg;

	// parameter defaults
	localparam int unsigned ERROR_WIDTH_DEF    = 16;
	localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
	localparam int unsigned INTEGRAL_WIDTH_DEF = 24;

	// fixed field widths
	localparam int unsigned GAIN_WIDTH      = 16;
	localparam int unsigned ILIM_WIDTH      = 23;
	localparam int unsigned DZONE_WIDTH     = 15;
	localparam int unsigned DLIM_WIDTH      = 15;
	localparam int unsigned DRIVE_WIDTH     = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 3;
	localparam int unsigned CFG_DATA_WIDTH  = 23;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEAD_ZONE      = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_LIMIT    = 3'd5;

	// configuration seen by the datapath
	typedef struct packed {
		logic [GAIN_WIDTH-1:0]  gain_p;
		logic [GAIN_WIDTH-1:0]  gain_i;
		logic [GAIN_WIDTH-1:0]  gain_d;
		logic [ILIM_WIDTH-1:0]  integral_limit;
		logic [DZONE_WIDTH-1:0] dead_zone;
		logic [DLIM_WIDTH-1:0]  drive_limit;
		logic                   clear;
	} pdc_cfg_t;

	// pipeline moves: accept into s1, s1 to s2, s2 to s3, s3 to output
	typedef struct packed {
		logic acc;
		logic mv1;
		logic mv2;
		logic mv3;
	} pdc_ctl_t;

endpackage

// ===== rtl/core/pdc_cfg.sv =====
// pdc_cfg: configuration registers of the pid core and the state clear pulse
// depends on pdc_pkg
module pdc_cfg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic [pdc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [pdc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
	output pdc_pkg::pdc_cfg_t                      cfg
);

	logic [pdc_pkg::GAIN_WIDTH-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [pdc_pkg::ILIM_WIDTH-1:0]  integral_limit_q;
	logic [pdc_pkg::DZONE_WIDTH-1:0] dead_zone_q;
	logic [pdc_pkg::DLIM_WIDTH-1:0]  drive_limit_q;
	logic                            hit;

	// decode of a listed register
	always_comb begin
		case (cfg_index)
			pdc_pkg::REG_GAIN_P,
			pdc_pkg::REG_GAIN_I,
			pdc_pkg::REG_GAIN_D,
			pdc_pkg::REG_INTEGRAL_LIMIT,
			pdc_pkg::REG_DEAD_ZONE,
			pdc_pkg::REG_DRIVE_LIMIT: hit = 1'b1;
			default:                  hit = 1'b0;
		endcase
	end

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= '0;
			dead_zone_q      <= '0;
			drive_limit_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pdc_pkg::REG_GAIN_P:         gain_p_q <= cfg_data[pdc_pkg::GAIN_WIDTH-1:0];
				pdc_pkg::REG_GAIN_I:         gain_i_q <= cfg_data[pdc_pkg::GAIN_WIDTH-1:0];
				pdc_pkg::REG_GAIN_D:         gain_d_q <= cfg_data[pdc_pkg::GAIN_WIDTH-1:0];
				pdc_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[pdc_pkg::ILIM_WIDTH-1:0];
				pdc_pkg::REG_DEAD_ZONE:      dead_zone_q <= cfg_data[pdc_pkg::DZONE_WIDTH-1:0];
				pdc_pkg::REG_DRIVE_LIMIT:    drive_limit_q <= cfg_data[pdc_pkg::DLIM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// any listed write also clears integral and previous error
	assign cfg.gain_p         = gain_p_q;
	assign cfg.gain_i         = gain_i_q;
	assign cfg.gain_d         = gain_d_q;
	assign cfg.integral_limit = integral_limit_q;
	assign cfg.dead_zone      = dead_zone_q;
	assign cfg.drive_limit    = drive_limit_q;
	assign cfg.clear          = cfg_valid & hit;

endmodule

// ===== rtl/core/pdc_integ.sv =====
// pdc_integ: input register, dead zone, clamped integral and difference stage
// holds the controller state; depends on pdc_pkg
module pdc_integ #(
	parameter int unsigned ERROR_WIDTH    = pdc_pkg::ERROR_WIDTH_DEF,
	parameter int unsigned INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pdc_pkg::pdc_ctl_t                ctl,
	input  pdc_pkg::pdc_cfg_t                cfg,
	input  logic signed [ERROR_WIDTH-1:0]    error_sample,
	output logic signed [ERROR_WIDTH-1:0]    err_s2,
	output logic signed [INTEGRAL_WIDTH-1:0] integ_s2,
	output logic signed [ERROR_WIDTH:0]      diff_s2
);

	localparam int unsigned EW = ERROR_WIDTH;
	localparam int unsigned IW = INTEGRAL_WIDTH;
	localparam int unsigned MW = (EW + 1 > pdc_pkg::DZONE_WIDTH) ? EW + 1 : pdc_pkg::DZONE_WIDTH;
	localparam int unsigned W0 = (IW > EW) ? IW : EW;
	localparam int unsigned SW = ((W0 > pdc_pkg::ILIM_WIDTH + 1) ? W0 : pdc_pkg::ILIM_WIDTH + 1) + 1;
	localparam logic signed [SW-1:0] IMAX = $signed({{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}});
	localparam logic signed [SW-1:0] IMIN = ~IMAX;

	logic signed [EW-1:0] error_s1;
	logic signed [EW-1:0] prev_q;
	logic signed [IW-1:0] integ_q;
	logic signed [EW:0]   e_x;
	logic        [EW:0]   mag;
	logic        [MW-1:0] mag_w, dz_w;
	logic signed [EW-1:0] ez;
	logic signed [SW-1:0] isum, ilim, iclamp, inext;

	// input register
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			error_s1 <= error_sample;
		end
	end

	// dead zone on the magnitude
	assign e_x   = (EW+1)'(error_s1);
	assign mag   = e_x[EW] ? $unsigned(-e_x) : $unsigned(e_x);
	assign mag_w = MW'(mag);
	assign dz_w  = MW'(cfg.dead_zone);
	assign ez    = (mag_w < dz_w) ? '0 : error_s1;

	// integral, clamped to the limit and to its own range
	always_comb begin
		isum = SW'(integ_q) + SW'(ez);
		ilim = $signed(SW'(cfg.integral_limit));
		if (isum > ilim) begin
			iclamp = ilim;
		end else if (isum < -ilim) begin
			iclamp = -ilim;
		end else begin
			iclamp = isum;
		end
		if (iclamp > IMAX) begin
			inext = IMAX;
		end else if (iclamp < IMIN) begin
			inext = IMIN;
		end else begin
			inext = iclamp;
		end
	end

	// state update, cleared by a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (cfg.clear) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else if (ctl.mv1) begin
			prev_q  <= ez;
			integ_q <= IW'(inext);
		end
	end

	// difference against the previous zoned error
	always_ff @(posedge clk) begin
		if (ctl.mv1) begin
			diff_s2 <= (EW+1)'(ez) - (EW+1)'(prev_q);
		end
	end

	// the state registers double as the s2 payload
	assign err_s2   = prev_q;
	assign integ_s2 = integ_q;

endmodule

// ===== rtl/core/pdc_mult.sv =====
// pdc_mult: the three gain products, scaled by the fraction bits, registered
// depends on pdc_pkg
module pdc_mult #(
	parameter int unsigned ERROR_WIDTH    = pdc_pkg::ERROR_WIDTH_DEF,
	parameter int unsigned GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF,
	parameter int unsigned INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                                clk,
	input  pdc_pkg::pdc_ctl_t                   ctl,
	input  pdc_pkg::pdc_cfg_t                   cfg,
	input  logic signed [ERROR_WIDTH-1:0]       err_s2,
	input  logic signed [INTEGRAL_WIDTH-1:0]    integ_s2,
	input  logic signed [ERROR_WIDTH:0]         diff_s2,
	output logic signed [pdc_pkg::GAIN_WIDTH+ERROR_WIDTH-GAIN_FRAC_BITS-1:0]    prod_p_s3,
	output logic signed [pdc_pkg::GAIN_WIDTH+INTEGRAL_WIDTH-GAIN_FRAC_BITS-1:0] prod_i_s3,
	output logic signed [pdc_pkg::GAIN_WIDTH+ERROR_WIDTH-GAIN_FRAC_BITS:0]      prod_d_s3
);

	localparam int unsigned GW  = pdc_pkg::GAIN_WIDTH;
	localparam int unsigned F   = GAIN_FRAC_BITS;
	localparam int unsigned MPW = GW + ERROR_WIDTH;
	localparam int unsigned MIW = GW + INTEGRAL_WIDTH;
	localparam int unsigned MDW = GW + ERROR_WIDTH + 1;

	logic signed [MPW-1:0] mul_p;
	logic signed [MIW-1:0] mul_i;
	logic signed [MDW-1:0] mul_d;

	// full products
	assign mul_p = $signed(cfg.gain_p) * err_s2;
	assign mul_i = $signed(cfg.gain_i) * integ_s2;
	assign mul_d = $signed(cfg.gain_d) * diff_s2;

	// arithmetic shift drops the fraction, rounding toward minus infinity
	always_ff @(posedge clk) begin
		if (ctl.mv2) begin
			prod_p_s3 <= (MPW-F)'(mul_p >>> F);
			prod_i_s3 <= (MIW-F)'(mul_i >>> F);
			prod_d_s3 <= (MDW-F)'(mul_d >>> F);
		end
	end

endmodule

// ===== rtl/core/pdc_sat.sv =====
// pdc_sat: sum of the scaled products, output clamp and saturation flag
// depends on pdc_pkg
module pdc_sat #(
	parameter int unsigned ERROR_WIDTH    = pdc_pkg::ERROR_WIDTH_DEF,
	parameter int unsigned GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF,
	parameter int unsigned INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                                clk,
	input  pdc_pkg::pdc_ctl_t                   ctl,
	input  pdc_pkg::pdc_cfg_t                   cfg,
	input  logic signed [pdc_pkg::GAIN_WIDTH+ERROR_WIDTH-GAIN_FRAC_BITS-1:0]    prod_p_s3,
	input  logic signed [pdc_pkg::GAIN_WIDTH+INTEGRAL_WIDTH-GAIN_FRAC_BITS-1:0] prod_i_s3,
	input  logic signed [pdc_pkg::GAIN_WIDTH+ERROR_WIDTH-GAIN_FRAC_BITS:0]      prod_d_s3,
	output logic signed [pdc_pkg::DRIVE_WIDTH-1:0] drive_value_q,
	output logic                                drive_saturated_q
);

	localparam int unsigned PIW = pdc_pkg::GAIN_WIDTH + INTEGRAL_WIDTH - GAIN_FRAC_BITS;
	localparam int unsigned PDW = pdc_pkg::GAIN_WIDTH + ERROR_WIDTH + 1 - GAIN_FRAC_BITS;
	localparam int unsigned TW  = ((PIW > PDW) ? PIW : PDW) + 2;

	logic signed [TW-1:0] sum, dlim, clamped;
	logic                 sat;

	// three-term sum and symmetric clamp
	always_comb begin
		sum  = TW'(prod_p_s3) + TW'(prod_i_s3) + TW'(prod_d_s3);
		dlim = $signed(TW'(cfg.drive_limit));
		sat  = 1'b1;
		if (sum > dlim) begin
			clamped = dlim;
		end else if (sum < -dlim) begin
			clamped = -dlim;
		end else begin
			clamped = sum;
			sat     = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.mv3) begin
			drive_value_q     <= pdc_pkg::DRIVE_WIDTH'(clamped);
			drive_saturated_q <= sat;
		end
	end

endmodule

// ===== rtl/core/pid_controller_deadband_clamp_core.sv =====
// pid_controller_deadband_clamp_core: top level of the positional pid core
// depends on pdc_pkg, pdc_cfg, pdc_integ, pdc_mult, pdc_sat
//
//  channel  direction  handshake              payload
//  in       to core    in_valid / in_stall    error_sample
//  out      from core  out_valid / out_stall  drive_value, drive_saturated
//  cfg      to core    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle sustained while out_stall is low, set by the integral loop on the state register
// a taken request passes in turn the input register, integral stage, product stage and
// result register; each stage has its own valid bit, so requests
// are taken while a result waits on out_stall until all four stages hold work
// arst_n clears valid bits, configuration registers, integral and previous error
// cfg_ready is always high; a write to a listed register also clears the state
module pid_controller_deadband_clamp_core #(
	parameter int unsigned ERROR_WIDTH    = pdc_pkg::ERROR_WIDTH_DEF,
	parameter int unsigned GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF,
	parameter int unsigned INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ERROR_WIDTH-1:0]        error_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pdc_pkg::DRIVE_WIDTH-1:0] drive_value,
	output logic                                 drive_saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pdc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [pdc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	localparam int unsigned GW  = pdc_pkg::GAIN_WIDTH;
	localparam int unsigned PPW = GW + ERROR_WIDTH - GAIN_FRAC_BITS;
	localparam int unsigned PIW = GW + INTEGRAL_WIDTH - GAIN_FRAC_BITS;
	localparam int unsigned PDW = GW + ERROR_WIDTH + 1 - GAIN_FRAC_BITS;

	pdc_pkg::pdc_cfg_t cfg;
	pdc_pkg::pdc_ctl_t ctl;

	logic v_s1_q, v_s2_q, v_s3_q, v_out_q;
	logic free_out, free3, free2, free1;

	logic signed [ERROR_WIDTH-1:0]    err_s2;
	logic signed [INTEGRAL_WIDTH-1:0] integ_s2;
	logic signed [ERROR_WIDTH:0]      diff_s2;
	logic signed [PPW-1:0]            prod_p_s3;
	logic signed [PIW-1:0]            prod_i_s3;
	logic signed [PDW-1:0]            prod_d_s3;

	// stage moves, each stage loads when empty or when it passes its work on
	assign free_out = ~v_out_q | ~out_stall;
	assign free3    = ~v_s3_q | free_out;
	assign free2    = ~v_s2_q | free3;
	assign free1    = ~v_s1_q | free2;
	assign ctl.acc  = in_valid & free1;
	assign ctl.mv1  = v_s1_q & free2;
	assign ctl.mv2  = v_s2_q & free3;
	assign ctl.mv3  = v_s3_q & free_out;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			v_s3_q  <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			v_s1_q  <= ctl.acc | (v_s1_q & ~free2);
			v_s2_q  <= ctl.mv1 | (v_s2_q & ~free3);
			v_s3_q  <= ctl.mv2 | (v_s3_q & ~free_out);
			v_out_q <= ctl.mv3 | (v_out_q & out_stall);
		end
	end

	assign in_stall  = ~free1;
	assign out_valid = v_out_q;
	assign cfg_ready = 1'b1;

	// configuration registers
	pdc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// dead zone, integral and difference
	pdc_integ #(
		.ERROR_WIDTH    (ERROR_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_integ (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cfg          (cfg),
		.error_sample (error_sample),
		.err_s2       (err_s2),
		.integ_s2     (integ_s2),
		.diff_s2      (diff_s2)
	);

	// gain products
	pdc_mult #(
		.ERROR_WIDTH    (ERROR_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_mult (
		.clk       (clk),
		.ctl       (ctl),
		.cfg       (cfg),
		.err_s2    (err_s2),
		.integ_s2  (integ_s2),
		.diff_s2   (diff_s2),
		.prod_p_s3 (prod_p_s3),
		.prod_i_s3 (prod_i_s3),
		.prod_d_s3 (prod_d_s3)
	);

	// sum and output clamp
	pdc_sat #(
		.ERROR_WIDTH    (ERROR_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_sat (
		.clk               (clk),
		.ctl               (ctl),
		.cfg               (cfg),
		.prod_p_s3         (prod_p_s3),
		.prod_i_s3         (prod_i_s3),
		.prod_d_s3         (prod_d_s3),
		.drive_value_q     (drive_value),
		.drive_saturated_q (drive_saturated)
	);

endmodule

// ===== rtl/core/pdc_checker.sv =====
// pdc_checker: port-level assertions on the pid core, bound to its top level
// depends on pdc_pkg and pid_controller_deadband_clamp_core
module pdc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [pdc_pkg::DRIVE_WIDTH-1:0]      drive_value,
	input logic                                 drive_saturated,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready
);

	localparam logic [pdc_pkg::DRIVE_WIDTH-1:0] DRIVE_MIN = {1'b1, {(pdc_pkg::DRIVE_WIDTH-1){1'b0}}};

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_value)
			&& $stable(drive_saturated))
		else $error("stalled result changed");

	// the clamp limit never reaches the most negative code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_value != DRIVE_MIN)
		else $error("drive value outside clamp range");

	// with no result waiting the pipeline always has room
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

	// configuration writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind pid_controller_deadband_clamp_core pdc_checker u_pdc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.drive_value     (drive_value),
	.drive_saturated (drive_saturated),
	.cfg_valid       (cfg_valid),
	.cfg_ready       (cfg_ready)
);

// ===== tb/pid_controller_deadband_clamp_core_test.sv =====
`timescale 1ns / 1ps
// pid_controller_deadband_clamp_core_test: self-checking bench for the pid core, with its own
// fixed-point predictor, directed corner cases, random register settings and random idling
// depends on pdc_pkg and pid_controller_deadband_clamp_core
module pid_controller_deadband_clamp_core_test;

	localparam int unsigned ERR_W   = pdc_pkg::ERROR_WIDTH_DEF;
	localparam int unsigned FRAC    = pdc_pkg::GAIN_FRAC_BITS_DEF;
	localparam int unsigned INTEG_W = pdc_pkg::INTEGRAL_WIDTH_DEF;

	// indexes past the register list, writes there must leave everything alone
	localparam logic [pdc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
	localparam logic [pdc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic signed [pdc_pkg::DRIVE_WIDTH-1:0] value;
		logic                                   saturated;
	} drive_t;

	logic                                     clk = 1'b0;
	logic                                     arst_n = 1'b0;
	logic                                     in_valid = 1'b0;
	logic                                     in_stall;
	logic signed [ERR_W-1:0]                  error_sample = '0;
	logic                                     out_valid;
	logic                                     out_stall = 1'b0;
	logic signed [pdc_pkg::DRIVE_WIDTH-1:0]   drive_value;
	logic                                     drive_saturated;
	logic                                     cfg_valid = 1'b0;
	logic                                     cfg_ready;
	logic [pdc_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index = '0;
	logic [pdc_pkg::CFG_DATA_WIDTH-1:0]       cfg_data = '0;

	// predictor copy of the registers and the controller state
	logic signed [pdc_pkg::GAIN_WIDTH-1:0]    kp = '0;
	logic signed [pdc_pkg::GAIN_WIDTH-1:0]    ki = '0;
	logic signed [pdc_pkg::GAIN_WIDTH-1:0]    kd = '0;
	logic [pdc_pkg::ILIM_WIDTH-1:0]           integ_lim = '0;
	logic [pdc_pkg::DZONE_WIDTH-1:0]          zone = '0;
	logic [pdc_pkg::DLIM_WIDTH-1:0]           out_lim = '0;
	logic signed [ERR_W-1:0]                  last_error = '0;
	logic signed [INTEG_W-1:0]                error_sum = '0;

	drive_t drive_expected[$];
	int     mismatch_count = 0;
	int     idle_cycles = 0;
	bit     sender_idling = 1'b0;
	bit     receiver_idling = 1'b0;
	bit     hold_request = 1'b0;

	pid_controller_deadband_clamp_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.error_sample    (error_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.drive_value     (drive_value),
		.drive_saturated (drive_saturated),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint clip(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// register write as the core sees it; listed registers also clear the state
	function automatic void apply_register(
			input logic [pdc_pkg::CFG_INDEX_WIDTH-1:0] index,
			input logic [pdc_pkg::CFG_DATA_WIDTH-1:0] data);
		case (index)
			pdc_pkg::REG_GAIN_P:         kp = data[pdc_pkg::GAIN_WIDTH-1:0];
			pdc_pkg::REG_GAIN_I:         ki = data[pdc_pkg::GAIN_WIDTH-1:0];
			pdc_pkg::REG_GAIN_D:         kd = data[pdc_pkg::GAIN_WIDTH-1:0];
			pdc_pkg::REG_INTEGRAL_LIMIT: integ_lim = data[pdc_pkg::ILIM_WIDTH-1:0];
			pdc_pkg::REG_DEAD_ZONE:      zone = data[pdc_pkg::DZONE_WIDTH-1:0];
			pdc_pkg::REG_DRIVE_LIMIT:    out_lim = data[pdc_pkg::DLIM_WIDTH-1:0];
			default:                     return;
		endcase
		last_error = '0;
		error_sum = '0;
	endfunction

	// one controller step: dead zone, clamped integral, derivative, sum of q8.8 gain products, output clamp
	function automatic drive_t compute_drive(input logic signed [ERR_W-1:0] sample);
		longint e;
		longint mag;
		longint acc;
		longint diff;
		longint total;
		longint clipped;
		drive_t r;
		e = sample;
		mag = (e < 0) ? -e : e;
		if (mag < longint'(zone))
			e = 0;
		// the limit never exceeds the integral range, so this clamp is the only one
		acc = clip(longint'(error_sum) + e, longint'(integ_lim));
		error_sum = acc[INTEG_W-1:0];
		diff = e - longint'(last_error);
		last_error = e[ERR_W-1:0];
		total = ((longint'(kp) * e) >>> FRAC) + ((longint'(ki) * acc) >>> FRAC)
			+ ((longint'(kd) * diff) >>> FRAC);
		clipped = clip(total, longint'(out_lim));
		r.value = clipped[pdc_pkg::DRIVE_WIDTH-1:0];
		r.saturated = (clipped != total);
		return r;
	endfunction

	// offer one request, hold it until taken, then record its expected drive
	task automatic send_error(input logic signed [ERR_W-1:0] sample);
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		error_sample <= sample;
		do @(posedge clk); while (in_stall !== 1'b0);
		drive_expected.push_back(compute_drive(sample));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
	endtask

	// keeps cfg_valid high so writes can follow back to back; caller lowers it
	task automatic write_register(input logic [pdc_pkg::CFG_INDEX_WIDTH-1:0] index,
			input logic [pdc_pkg::CFG_DATA_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		apply_register(index, data);
	endtask

	// full register set once the core is idle; unused upper data bits get junk
	task automatic configure(input logic [pdc_pkg::GAIN_WIDTH-1:0] gp,
			input logic [pdc_pkg::GAIN_WIDTH-1:0] gi,
			input logic [pdc_pkg::GAIN_WIDTH-1:0] gd,
			input logic [pdc_pkg::ILIM_WIDTH-1:0] il,
			input logic [pdc_pkg::DZONE_WIDTH-1:0] dz,
			input logic [pdc_pkg::DLIM_WIDTH-1:0] dl);
		wait_drained();
		write_register(pdc_pkg::REG_GAIN_P, {7'($urandom), gp});
		write_register(pdc_pkg::REG_GAIN_I, {7'($urandom), gi});
		write_register(pdc_pkg::REG_GAIN_D, {7'($urandom), gd});
		write_register(pdc_pkg::REG_INTEGRAL_LIMIT, il);
		write_register(pdc_pkg::REG_DEAD_ZONE, {8'($urandom), dz});
		write_register(pdc_pkg::REG_DRIVE_LIMIT, {8'($urandom), dl});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [pdc_pkg::GAIN_WIDTH-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 16'h8000;
			2:       return 16'h7fff;
			5:       return 16'($urandom);
			default: return 16'($urandom_range(0, 1024) - 512);
		endcase
	endfunction

	task automatic configure_random();
		logic [pdc_pkg::ILIM_WIDTH-1:0]  il;
		logic [pdc_pkg::DZONE_WIDTH-1:0] dz;
		logic [pdc_pkg::DLIM_WIDTH-1:0]  dl;
		case ($urandom_range(0, 4))
			0:       il = '0;
			1:       il = '1;
			2:       il = 23'($urandom);
			default: il = 23'($urandom_range(1, 5000));
		endcase
		case ($urandom_range(0, 4))
			0, 1:    dz = '0;
			2:       dz = '1;
			default: dz = 15'($urandom_range(1, 300));
		endcase
		case ($urandom_range(0, 4))
			0:       dl = '0;
			1:       dl = '1;
			2:       dl = 15'($urandom);
			default: dl = 15'($urandom_range(1, 2000));
		endcase
		configure(pick_gain(), pick_gain(), pick_gain(), il, dz, dl);
	endtask

	// mostly small errors, some full range, extremes and values around the dead zone
	function automatic logic signed [ERR_W-1:0] next_error();
		int mag;
		case ($urandom_range(0, 7))
			0: return ERR_W'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0:       return 16'h8000;
					1:       return 16'h7fff;
					2:       return '0;
					default: return '1;
				endcase
			end
			2: begin
				mag = int'(zone) + int'($urandom_range(0, 2)) - 1;
				if (mag < 0)
					mag = 0;
				return ERR_W'($urandom_range(0, 1) ? -mag : mag);
			end
			default: return ERR_W'($urandom_range(0, 800) - 400);
		endcase
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_error(next_error());
	endtask

	// reset registers are all zero, so even full-scale errors give no drive
	task automatic test_reset_state();
		send_error(16'sh8000);
		send_error(16'sh7fff);
	endtask

	// magnitudes just below and at the dead zone, output exactly at and past the limit
	task automatic test_dead_zone_and_limit();
		configure(16'd256, 16'd0, 16'd0, '0, 15'd100, 15'h7fff);
		send_error(16'sd99);
		send_error(-16'sd99);
		send_error(16'sd100);
		send_error(-16'sd100);
		send_error(16'sh7fff);
		send_error(16'sh8000);
	endtask

	// both limits zero: output forced to zero, flagged whenever the raw sum is not zero
	task automatic test_zero_limits();
		configure(16'h8000, 16'h7fff, 16'h7fff, '0, '0, '0);
		send_error(16'sd1);
		send_error(-16'sd1);
		send_error(16'sd0);
		send_error(16'sd0);
	endtask

	// integral pinned at either limit and landing exactly on it
	task automatic test_integral_clamp();
		configure(16'd0, 16'd256, 16'd0, 23'd1000, '0, 15'd20000);
		send_error(16'sh7fff);
		send_error(16'sh7fff);
		send_error(16'sh8000);
		send_error(16'sh8000);
		send_error(16'sd1000);
		send_error(16'sd1000);
	endtask

	// spare indexes keep the state, a single listed write clears it
	task automatic test_register_side_effects();
		wait_drained();
		write_register(REG_SPARE_A, '1);
		write_register(REG_SPARE_B, '0);
		cfg_valid <= 1'b0;
		send_error(16'sd7);
		send_error(-16'sd7);
		wait_drained();
		write_register(pdc_pkg::REG_DEAD_ZONE, 23'd5);
		cfg_valid <= 1'b0;
		send_error(16'sd3);
		send_error(16'sd10);
	endtask

	// extreme settings first, then random ones, each with a burst of random errors
	task automatic test_random_settings();
		configure('1 >> 1, '1 >> 1, '1 >> 1, '1, '1, '1);
		send_random($urandom_range(40, 90));
		configure(16'h8000, 16'h8000, 16'h8000, '0, '0, '0);
		send_random($urandom_range(40, 90));
		repeat (10) begin
			configure_random();
			send_random($urandom_range(40, 90));
		end
	endtask

	// receiver holds off long enough for the core to fill and stall its input
	task automatic test_output_backpressure();
		configure_random();
		hold_request = 1'b1;
		send_random(80);
	endtask

	task automatic test_full_rate();
		configure(16'd300, 16'd40, 16'h8000, 23'd20000, 15'd20, 15'd30000);
		send_random(250);
	endtask

	// receiver side: random stall bursts, or one long hold when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each delivered drive with the oldest expectation
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (drive_expected.size() == 0) begin
				$error("unexpected result: drive_value %0d drive_saturated %0b",
					drive_value, drive_saturated);
				mismatch_count++;
			end else begin
				want = drive_expected.pop_front();
				if (drive_value !== want.value) begin
					$error("drive_value: expected %0d, actual %0d", want.value, drive_value);
					mismatch_count++;
				end
				if (drive_saturated !== want.saturated) begin
					$error("drive_saturated: expected %0b, actual %0b", want.saturated,
						drive_saturated);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("pid_controller_deadband_clamp_core test failed");
			$finish;
		end
	end

	// test sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		sender_idling = 1'b1;
		receiver_idling = 1'b1;
		test_reset_state();
		test_dead_zone_and_limit();
		test_zero_limits();
		test_integral_clamp();
		test_register_side_effects();
		test_random_settings();
		test_output_backpressure();
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		test_full_rate();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && drive_expected.size() == 0)
			$display("pid_controller_deadband_clamp_core test passed");
		else
			$display("pid_controller_deadband_clamp_core test failed");
		$finish;
	end

endmodule
